// File: rtl/bounded_deque_with_search_assert.svh
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BDQS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BDQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bdqs_pkg.sv
// Shared types and constants of the bounded deque with search.
`default_nettype none

package bdqs_pkg;

    localparam int DATA_W       = 16;
    localparam int OP_W         = 3;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int CNT_OUT_W    = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_CONTAINS   = 3'd5,
        OP_GET        = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_FRONT,
        S_POP_BACK,
        S_GET,
        S_REM_FRONT,
        S_REM_BACK,
        S_SCAN,
        S_SHIFT,
        S_RD_FRONT,
        S_RD_BACK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/bdqs_if.sv
// Valid/ready channel interfaces for deque commands and responses.
`default_nettype none

interface bdqs_in_if import bdqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, op, value, position, input ready);
    modport sink   (input valid, op, value, position, output ready);
endinterface

interface bdqs_out_if import bdqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic                     found;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_OUT_W-1:0]     entry_count;

    modport source (output valid, data_out, found, status, front_value, back_value,
                    entry_count, input ready);
    modport sink   (input valid, data_out, found, status, front_value, back_value,
                    entry_count, output ready);
endinterface

`default_nettype wire

// File: rtl/bdqs_mem.sv
// Element store: one write port and one registered read port.
`default_nettype none

module bdqs_mem import bdqs_pkg::*; #(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/bdqs_slot.sv
// Shared slot unit: maps a logical index to a circular store slot.
`default_nettype none

module bdqs_slot import bdqs_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int SW       = $clog2(CAPACITY_DEF),
    parameter int CW       = $clog2(CAPACITY_DEF + 1)
) (
    input  wire logic [SW-1:0] i_head,
    input  wire logic [CW-1:0] i_idx,
    output logic      [SW-1:0] o_slot
);

    localparam int SUM_W = CW + 1;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;

    always_comb begin
        sum     = SUM_W'(i_head) + SUM_W'(i_idx);
        wrapped = (sum >= SUM_W'(CAPACITY)) ? (sum - SUM_W'(CAPACITY)) : sum;
        o_slot  = wrapped[SW-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/bounded_deque_with_search.sv
// One command is in work at a time: a command beat is taken only in the idle state, and the
// next is not taken until the response of the last one has been registered.
// Contains and remove scan the stored entries; the single store read port and the shared
// slot adder visit one entry per cycle during a scan.
// A new command is taken while the previous response beat still waits.
// Synchronous active-low reset empties the deque; no clearing pass is needed.
`default_nettype none

module bounded_deque_with_search import bdqs_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bdqs_in_if.sink     i_cmd,
    bdqs_out_if.source  o_rsp
);

    `include "bounded_deque_with_search_assert.svh"

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state                   r_state, n_state;
    logic [SW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_lim, n_lim;
    logic                     r_pend, n_pend;
    logic [SW-1:0]            r_ra1, n_ra1;
    logic [SW-1:0]            r_ra2, n_ra2;
    t_op                      r_op, n_op;
    logic [DATA_W-1:0]        r_val, n_val;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [DATA_W-1:0]        r_data, n_data;
    logic                     r_found, n_found;
    t_status                  r_status, n_status;
    logic [DATA_W-1:0]        r_front, n_front;
    logic                     r_ovalid, n_ovalid;
    logic [DATA_W-1:0]        r_o_data, n_o_data;
    logic                     r_o_found, n_o_found;
    t_status                  r_o_status, n_o_status;
    logic [DATA_W-1:0]        r_o_front, n_o_front;
    logic [DATA_W-1:0]        r_o_back, n_o_back;
    logic [CNT_OUT_W-1:0]     r_o_count, n_o_count;

    logic [CW-1:0]            unit_idx;
    logic [SW-1:0]            unit_slot;
    logic                     mem_we;
    logic [SW-1:0]            mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic [SW-1:0]            mem_raddr;
    logic [DATA_W-1:0]        mem_rdata;
    logic                     full;
    logic                     empty;
    logic                     out_free;
    logic                     rd_match;
    logic                     issue;

    bdqs_slot #(.CAPACITY(CAPACITY), .SW(SW), .CW(CW)) u_slot (
        .i_head (r_head),
        .i_idx  (unit_idx),
        .o_slot (unit_slot)
    );

    bdqs_mem #(.DEPTH(CAPACITY), .AW(SW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign full     = (r_count >= CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign out_free = !r_ovalid || o_rsp.ready;
    assign rd_match = (mem_rdata == r_val);

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.data_out    = r_o_data;
    assign o_rsp.found       = r_o_found;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.front_value = r_o_front;
    assign o_rsp.back_value  = r_o_back;
    assign o_rsp.entry_count = r_o_count;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_lim      = r_lim;
        n_pend     = r_pend;
        n_ra1      = r_ra1;
        n_ra2      = r_ra2;
        n_op       = r_op;
        n_val      = r_val;
        n_pos      = r_pos;
        n_data     = r_data;
        n_found    = r_found;
        n_status   = r_status;
        n_front    = r_front;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        n_o_data   = r_o_data;
        n_o_found  = r_o_found;
        n_o_status = r_o_status;
        n_o_front  = r_o_front;
        n_o_back   = r_o_back;
        n_o_count  = r_o_count;
        unit_idx   = '0;
        mem_we     = 1'b0;
        mem_waddr  = unit_slot;
        mem_wdata  = r_val;
        mem_raddr  = unit_slot;
        issue      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op     = t_op'(i_cmd.op);
                    n_val    = i_cmd.value;
                    n_pos    = i_cmd.position;
                    n_data   = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RD_FRONT;
                case (r_op)
                    OP_PUSH_BACK: begin
                        unit_idx = r_count;
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_PUSH_FRONT: begin
                        unit_idx = CW'(CAPACITY - 1);
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_head  = unit_slot;
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_POP_FRONT: begin
                        unit_idx = '0;
                        if (empty) begin
                            n_status = ST_MISS;
                        end else begin
                            n_state = S_POP_FRONT;
                        end
                    end
                    OP_POP_BACK: begin
                        unit_idx = r_count - CW'(1);
                        if (empty) begin
                            n_status = ST_MISS;
                        end else begin
                            n_state = S_POP_BACK;
                        end
                    end
                    OP_REMOVE: begin
                        unit_idx = '0;
                        if (empty) begin
                            n_status = ST_MISS;
                        end else begin
                            n_state = S_REM_FRONT;
                        end
                    end
                    OP_CONTAINS: begin
                        n_idx   = '0;
                        n_lim   = r_count;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                    OP_GET: begin
                        if (PW'(r_pos) < PW'(r_count)) begin
                            unit_idx = CW'(r_pos);
                            n_state  = S_GET;
                        end else begin
                            n_status = ST_MISS;
                        end
                    end
                    default: begin
                        n_state = S_RD_FRONT;
                    end
                endcase
            end
            S_POP_FRONT: begin
                unit_idx = CW'(1);
                n_data   = mem_rdata;
                n_head   = unit_slot;
                n_count  = r_count - CW'(1);
                n_state  = S_RD_FRONT;
            end
            S_POP_BACK: begin
                n_data  = mem_rdata;
                n_count = r_count - CW'(1);
                n_state = S_RD_FRONT;
            end
            S_GET: begin
                n_data  = mem_rdata;
                n_state = S_RD_FRONT;
            end
            S_REM_FRONT: begin
                if (rd_match) begin
                    unit_idx = CW'(1);
                    n_head   = unit_slot;
                    n_count  = r_count - CW'(1);
                    n_found  = 1'b1;
                    n_state  = S_RD_FRONT;
                end else begin
                    unit_idx = r_count - CW'(1);
                    n_state  = S_REM_BACK;
                end
            end
            S_REM_BACK: begin
                if (rd_match) begin
                    n_count = r_count - CW'(1);
                    n_found = 1'b1;
                    n_state = S_RD_FRONT;
                end else begin
                    n_idx   = CW'(1);
                    n_lim   = r_count - CW'(1);
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                unit_idx = r_idx;
                if (r_pend && rd_match) begin
                    n_found = 1'b1;
                    n_pend  = 1'b0;
                    n_state = (r_op == OP_REMOVE) ? S_SHIFT : S_RD_FRONT;
                end else begin
                    issue  = (r_idx < r_lim);
                    n_pend = issue;
                    if (issue) begin
                        n_ra1 = unit_slot;
                        n_idx = r_idx + CW'(1);
                    end else if (!r_pend) begin
                        n_status = ST_MISS;
                        n_state  = S_RD_FRONT;
                    end
                end
            end
            S_SHIFT: begin
                unit_idx  = r_idx;
                issue     = (r_idx < r_count);
                n_pend    = issue;
                mem_we    = r_pend;
                mem_waddr = r_ra2;
                mem_wdata = mem_rdata;
                if (issue) begin
                    n_ra1 = unit_slot;
                    n_ra2 = r_ra1;
                    n_idx = r_idx + CW'(1);
                end else if (!r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RD_FRONT;
                end
            end
            S_RD_FRONT: begin
                unit_idx = '0;
                n_state  = S_RD_BACK;
            end
            S_RD_BACK: begin
                unit_idx = r_count - CW'(1);
                n_front  = empty ? '0 : mem_rdata;
                n_state  = S_DONE;
            end
            S_DONE: begin
                unit_idx = r_count - CW'(1);
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_data   = r_data;
                    n_o_found  = r_found;
                    n_o_status = r_status;
                    n_o_front  = r_front;
                    n_o_back   = empty ? '0 : mem_rdata;
                    n_o_count  = CNT_OUT_W'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_lim      <= n_lim;
        r_ra1      <= n_ra1;
        r_ra2      <= n_ra2;
        r_op       <= n_op;
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_data     <= n_data;
        r_found    <= n_found;
        r_status   <= n_status;
        r_front    <= n_front;
        r_o_data   <= n_o_data;
        r_o_found  <= n_o_found;
        r_o_status <= n_o_status;
        r_o_front  <= n_o_front;
        r_o_back   <= n_o_back;
        r_o_count  <= n_o_count;
    end

    `BDQS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY),
                     "Element count exceeds capacity.")
    `BDQS_ASSERT_NOW(a_full_status, i_clk, i_rst_n,
                     r_state == S_DONE && r_status == ST_FULL, r_count == CW'(CAPACITY),
                     "Full status reported on a deque that is not full.")
    `BDQS_ASSERT_NEXT(a_accept_hold, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready,
                      r_state == S_EXEC && r_count == $past(r_count),
                      "Command beat did not start execution cleanly.")

endmodule

`default_nettype wire
